// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CHK_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sfht_pkg.sv =====
//------------------------------------------------------------------------------
// Session flow hash table package
// Command and status codes and the hash constant.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfht_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_FIND   = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_MISUSE   = 2'd2;

    localparam logic [31:0] HASH_MULT = 32'h811c9dc5;

endpackage

`default_nettype wire

// ===== sv/session_flow_hash_table_core.sv =====
// Sequence: misuse or an unknown command answers straight from the hash state; else the
// hash unit runs, then a remove passes S_RM1 and S_RM2, a find passes S_HEAD, S_NODE and
// S_CMP, and an insert does the same and then S_LINK1 and S_LINK2; a bucket that is not
// empty adds one more S_NODE, and every node passed over adds S_NODE and S_CMP again.
// Throughput: one word at a time; the next is accepted the cycle after the result is loaded.
// Reset: a clearing pass over every bucket head and every node busy flag, no word accepted.
`timescale 1ns / 1ps
`default_nettype none

module session_flow_hash_table_core
    import sfht_pkg::*;
#(
    parameter int HASH_MOD   = 99991,
    parameter int POOL_NODES = 4096,
    parameter int KEY_BYTES  = 12
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // node_index[11:0], key_lo[75:12], key_hi[107:76], zero fill to 112
    input  wire logic [111:0]  s_tdata,
    // cmd[1:0]
    input  wire logic [1:0]    s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // status[1:0], found_node[13:2], entry_count[26:14], zero fill to 32
    output logic [31:0]        m_tdata
);

    localparam int BW = $clog2(HASH_MOD);
    localparam int NW = $clog2(POOL_NODES) + 1;
    localparam int IW = $clog2(POOL_NODES);
    localparam int CLR_LEN = (HASH_MOD > POOL_NODES) ? HASH_MOD : POOL_NODES;
    localparam int CLRW = $clog2(CLR_LEN);
    localparam logic [NW-1:0] NULLN = NW'(POOL_NODES);
    localparam logic [12:0] POOL13 = 13'(POOL_NODES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_HEAD, S_NODE, S_CMP, S_LINK1, S_LINK2,
        S_RM1, S_RM2, S_OUT
    } state_t;

    logic [NW-1:0] head_mem [HASH_MOD];
    logic [NW-1:0] next_mem [POOL_NODES];
    logic [NW-1:0] prev_mem [POOL_NODES];
    logic [95:0]   key_mem  [POOL_NODES];
    logic          busy_mem [POOL_NODES];

    state_t          state_reg;
    logic [CLRW-1:0] clr_reg;
    logic [1:0]    cmd_reg;
    logic [11:0]   node_reg;
    logic [95:0]   key_reg;
    logic [BW-1:0] bkt_reg;
    logic [NW-1:0] cur_reg, prv_reg, nx_reg, pv_reg;
    logic [12:0]   steps_reg;
    logic [12:0]   total_reg;
    logic [1:0]    status_reg;
    logic [11:0]   found_reg;
    logic          m_valid_reg;

    // Registered memory read data.
    logic [NW-1:0] head_rd, next_rd, prev_rd;
    logic [95:0]   key_rd;
    logic          busy_rd;

    logic           hstart_reg;
    logic           hash_done;
    logic [BW-1:0]  hbucket;
    logic [95:0]    hkey;

    assign hkey = (cmd_reg == CMD_REMOVE) ? key_rd : key_reg;

    sfht_hash #(.HASH_MOD(HASH_MOD), .KEY_BYTES(KEY_BYTES), .BW(BW)) u_hash (
        .aclk(aclk), .aresetn(aresetn), .start(hstart_reg),
        .key_lo(hkey[63:0]), .key_hi(hkey[95:64]),
        .done(hash_done), .bucket(hbucket)
    );

    // Key compare over the first KEY_BYTES bytes.
    function automatic logic key_eq(input logic [95:0] a, input logic [95:0] b);
        logic r;
        r = 1'b1;
        for (int i = 0; i < KEY_BYTES; i++)
            if (a[8*i +: 8] != b[8*i +: 8]) r = 1'b0;
        return r;
    endfunction

    logic       head_we, next_we, prev_we, key_we, busy_we;
    logic [BW-1:0] head_wa;
    logic [IW-1:0] next_wa, prev_wa, key_wa, busy_wa, rd_a;
    logic [NW-1:0] head_wd, next_wd, prev_wd;
    logic       busy_wd;
    logic       node_ok;

    assign node_ok = (32'(node_reg) < POOL_NODES);

    always_comb begin
        head_we = 1'b0; head_wa = bkt_reg; head_wd = NULLN;
        next_we = 1'b0; next_wa = node_reg[IW-1:0]; next_wd = cur_reg;
        prev_we = 1'b0; prev_wa = node_reg[IW-1:0]; prev_wd = prv_reg;
        key_we  = 1'b0; key_wa  = node_reg[IW-1:0];
        busy_we = 1'b0; busy_wa = node_reg[IW-1:0]; busy_wd = 1'b0;
        rd_a    = cur_reg[IW-1:0];
        case (state_reg)
            S_CLEAR: begin
                head_we = (32'(clr_reg) < HASH_MOD);
                head_wa = clr_reg[BW-1:0];
                busy_we = (32'(clr_reg) < POOL_NODES);
                busy_wa = clr_reg[IW-1:0];
            end
            S_IDLE: rd_a = s_tdata[IW-1:0];
            S_HASH: rd_a = node_reg[IW-1:0];
            S_LINK1: begin
                key_we = 1'b1; next_we = 1'b1; prev_we = 1'b1;
            end
            S_LINK2: begin
                busy_we = 1'b1; busy_wd = 1'b1;
                if (cur_reg != NULLN) begin
                    prev_we = 1'b1; prev_wa = cur_reg[IW-1:0];
                    prev_wd = {1'b0, node_reg[IW-1:0]};
                end
                if (prv_reg != NULLN) begin
                    next_we = 1'b1; next_wa = prv_reg[IW-1:0];
                    next_wd = {1'b0, node_reg[IW-1:0]};
                end else begin
                    head_we = 1'b1; head_wd = {1'b0, node_reg[IW-1:0]};
                end
            end
            S_RM1: begin
                busy_we = 1'b1;
                if (nx_reg != NULLN) begin
                    prev_we = 1'b1; prev_wa = nx_reg[IW-1:0]; prev_wd = pv_reg;
                end
            end
            S_RM2: begin
                if (pv_reg != NULLN) begin
                    next_we = 1'b1; next_wa = pv_reg[IW-1:0]; next_wd = nx_reg;
                end else begin
                    head_we = 1'b1; head_wd = nx_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (head_we) head_mem[head_wa] <= head_wd;
        head_rd <= head_mem[bkt_reg];
    end

    always_ff @(posedge aclk) begin
        if (next_we) next_mem[next_wa] <= next_wd;
        if (prev_we) prev_mem[prev_wa] <= prev_wd;
        if (key_we)  key_mem[key_wa]   <= key_reg;
        if (busy_we) busy_mem[busy_wa] <= busy_wd;
        next_rd <= next_mem[rd_a];
        prev_rd <= prev_mem[rd_a];
        key_rd  <= key_mem[rd_a];
        busy_rd <= busy_mem[rd_a];
    end

    logic hash_started_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
            hash_started_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && state_reg != S_OUT) m_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR: begin
                    if (32'(clr_reg) == CLR_LEN - 1) state_reg <= S_IDLE;
                    clr_reg <= clr_reg + CLRW'(1);
                end
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        cmd_reg   <= s_tuser;
                        node_reg  <= s_tdata[11:0];
                        key_reg   <= s_tdata[107:12];
                        found_reg <= '0;
                        hash_started_reg <= 1'b0;
                        state_reg <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (!hash_started_reg) begin
                        hash_started_reg <= 1'b1;
                        if (cmd_reg == CMD_INSERT && (!node_ok || busy_rd)) begin
                            status_reg <= ST_MISUSE; state_reg <= S_OUT;
                        end else if (cmd_reg == CMD_REMOVE) begin
                            if (!node_ok || !busy_rd) begin
                                status_reg <= ST_MISUSE; state_reg <= S_OUT;
                            end else begin
                                nx_reg <= next_rd; pv_reg <= prev_rd;
                            end
                        end else if (cmd_reg != CMD_INSERT && cmd_reg != CMD_FIND) begin
                            status_reg <= ST_MISUSE; state_reg <= S_OUT;
                        end
                    end else if (hash_done) begin
                        bkt_reg <= hbucket;
                        if (cmd_reg == CMD_REMOVE) begin
                            if (total_reg != '0) total_reg <= total_reg - 13'd1;
                            status_reg <= ST_DONE;
                            state_reg  <= S_RM1;
                        end else begin
                            state_reg <= S_HEAD;
                        end
                    end
                end
                S_HEAD: begin
                    // Head read issued this cycle, data in head_rd next.
                    prv_reg   <= NULLN;
                    steps_reg <= '0;
                    cur_reg   <= NULLN;
                    state_reg <= S_NODE;
                end
                S_NODE: begin
                    if (cur_reg == NULLN && steps_reg == '0 && prv_reg == NULLN) begin
                        cur_reg <= head_rd;
                        steps_reg <= 13'd1;
                        state_reg <= (head_rd == NULLN) ? S_CMP : S_NODE;
                    end else begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (cur_reg == NULLN || steps_reg > POOL13 ||
                        key_eq(key_rd, key_reg)) begin
                        if (cmd_reg == CMD_FIND) begin
                            if (cur_reg != NULLN && steps_reg <= POOL13) begin
                                status_reg <= ST_DONE;
                                found_reg  <= cur_reg[11:0];
                            end else begin
                                status_reg <= ST_NOTFOUND;
                            end
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_LINK1;
                        end
                    end else begin
                        prv_reg   <= cur_reg;
                        cur_reg   <= next_rd;
                        steps_reg <= steps_reg + 13'd1;
                        state_reg <= S_NODE;
                    end
                end
                S_LINK1: state_reg <= S_LINK2;
                S_LINK2: begin
                    total_reg  <= total_reg + 13'd1;
                    status_reg <= ST_DONE;
                    state_reg  <= S_OUT;
                end
                S_RM1: state_reg <= S_RM2;
                S_RM2: state_reg <= S_OUT;
                S_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    logic [31:0] out_word_reg;
    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && (!m_valid_reg || m_tready))
            out_word_reg <= {5'd0, total_reg, found_reg, status_reg};
    end
    assign m_tdata = out_word_reg;

    // The hash unit's start is registered, so it comes in the cycle after the hash state is
    // entered; for remove the stored key has arrived from the key memory by then.
    always_ff @(posedge aclk) begin
        if (!aresetn) hstart_reg <= 1'b0;
        else hstart_reg <= (state_reg == S_HASH) && !hash_started_reg &&
            ((cmd_reg == CMD_FIND) ||
             (cmd_reg == CMD_INSERT && node_ok && !busy_rd) ||
             (cmd_reg == CMD_REMOVE && node_ok && busy_rd));
    end

endmodule

`default_nettype wire

// ===== sv/sfht_hash.sv =====
//------------------------------------------------------------------------------
// Session flow hash unit
// Multiply-xor hash over the key bytes, one byte a cycle, then a reduction
// modulo HASH_MOD by folding the upper word and a reciprocal multiplication.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfht_hash
    import sfht_pkg::*;
#(
    parameter int HASH_MOD  = 99991,
    parameter int KEY_BYTES = 12,
    parameter int BW        = $clog2(HASH_MOD)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [63:0]   key_lo,
    input  wire logic [31:0]   key_hi,
    output logic               done,
    output logic [BW-1:0]      bucket
);

    localparam logic [63:0] MOD64  = 64'(HASH_MOD);
    // Residue of 2**32 for folding, and a reciprocal scaled by 2**(32+BW).
    localparam logic [16:0] FOLD_C = 17'((64'd1 << 32) % MOD64);
    localparam logic [32:0] RECIP  = 33'((64'd1 << (32 + BW)) / MOD64);

    typedef enum logic [2:0] {S_IDLE, S_MULT, S_FOLD, S_QUOT, S_REM, S_FIX} state_t;

    state_t        state_reg;
    logic [3:0]    byte_reg;
    logic [63:0]   h_reg;
    logic [95:0]   key_reg;
    logic [31:0]   q_reg;

    logic [63:0] lo_prod;
    logic [31:0] hi_prod;
    logic [63:0] h_mult;
    logic [7:0]  kb;
    logic [63:0] h_fold;
    logic [64:0] q_prod;
    logic [63:0] r_prod;

    // The 64x32 product is built from two 32x32 halves.
    always_comb begin
        lo_prod = 64'(h_reg[31:0]) * 64'(HASH_MULT);
        hi_prod = h_reg[63:32] * HASH_MULT;
        h_mult  = lo_prod + {hi_prod, 32'd0};
        kb      = key_reg[8*byte_reg +: 8];
        h_fold  = 64'(h_reg[63:32]) * 64'(FOLD_C) + 64'(h_reg[31:0]);
        q_prod  = 65'(h_reg[31:0]) * 65'(RECIP);
        r_prod  = 64'(q_reg) * MOD64;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
        end else begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        key_reg   <= {key_hi, key_lo};
                        h_reg     <= '0;
                        byte_reg  <= '0;
                        state_reg <= S_MULT;
                    end
                end
                S_MULT: begin
                    h_reg    <= h_mult ^ 64'(kb);
                    byte_reg <= byte_reg + 4'd1;
                    if (32'(byte_reg) == KEY_BYTES - 1)
                        state_reg <= S_FOLD;
                end
                S_FOLD: begin
                    // At most four folds bring the value below 2**32.
                    if (h_reg[63:32] == '0)
                        state_reg <= S_QUOT;
                    else
                        h_reg <= h_fold;
                end
                S_QUOT: begin
                    q_reg     <= 32'(q_prod >> (32 + BW));
                    state_reg <= S_REM;
                end
                S_REM: begin
                    // The quotient estimate is at most one short.
                    h_reg     <= h_reg - r_prod;
                    state_reg <= S_FIX;
                end
                S_FIX: begin
                    if (h_reg >= MOD64)
                        h_reg <= h_reg - MOD64;
                    done      <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign bucket = h_reg[BW-1:0];

endmodule

`default_nettype wire

// ===== sv/sfht_checker.sv =====
//------------------------------------------------------------------------------
// Session flow hash table checker
// Port-level checks on the stream handshake and result contents.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sfht_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [31:0]  m_tdata
);

    `CHK_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")
    `CHK_IMPL(a_status_code, aclk, aresetn, m_tvalid, m_tdata[1:0] != 2'd3, "illegal status code")
    `CHK_IMPL(a_found_zero, aclk, aresetn, m_tvalid && m_tdata[1:0] != 2'd0, m_tdata[13:2] == 12'd0 || m_tdata[1:0] == 2'd0, "found node set without a hit")
    `CHK_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second word accepted while busy")

endmodule

bind session_flow_hash_table_core sfht_checker u_sfht_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Session flow hash table testbench
// Drives insert, remove, find and unknown command words into the core, predicts every result
// with a model of the chained buckets of its own, and checks each result
// word field by field while both sides idle and stall in several phases.
//------------------------------------------------------------------------------

module testbench;
    import sfht_pkg::*;

    localparam int BUCKETS = 99991;
    localparam int NODES = 4096;
    localparam logic [12:0] NIL = 13'(NODES);
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int RANDOM_WORDS = 1000;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] node;
        logic [63:0] key_lo;
        logic [31:0] key_hi;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] found;
        logic [12:0] count;
    } reply_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [111:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;

    session_flow_hash_table_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    // Shadow of the table.
    logic [12:0] head [BUCKETS];
    logic [12:0] next_of [NODES];
    logic [12:0] prev_of [NODES];
    logic [63:0] key_lo_of [NODES];
    logic [31:0] key_hi_of [NODES];
    bit          busy [NODES];
    logic [12:0] linked;

    request_t pending_words [$];
    reply_t   awaited_replies [$];
    logic [95:0] key_pool [$];
    int in_accepted = 0;
    int drv_issued = 0;
    int failures = 0;
    int quiet_cycles = 0;
    int total_words = 0;

    function automatic int unsigned bucket_for(logic [63:0] lo, logic [31:0] hi);
        logic [63:0] h;
        logic [95:0] k;
        h = '0;
        k = {hi, lo};
        for (int i = 0; i < 12; i++)
            h = (h * 64'(HASH_MULT)) ^ 64'(k[8*i +: 8]);
        return int'(h % 64'(BUCKETS));
    endfunction

    function automatic reply_t apply_command(request_t rq);
        reply_t r;
        logic [12:0] cur, prv, nx, pv;
        int unsigned b;
        int steps;
        r = '{status: ST_MISUSE, found: '0, count: '0};
        if (rq.cmd == CMD_INSERT && !busy[rq.node]) begin
            b = bucket_for(rq.key_lo, rq.key_hi);
            prv = NIL;
            cur = head[b];
            steps = 0;
            while (cur < NIL && steps < NODES &&
                   !(key_lo_of[cur] == rq.key_lo && key_hi_of[cur] == rq.key_hi)) begin
                prv = cur;
                cur = next_of[cur];
                steps++;
            end
            key_lo_of[rq.node] = rq.key_lo;
            key_hi_of[rq.node] = rq.key_hi;
            next_of[rq.node] = cur;
            prev_of[rq.node] = prv;
            if (cur < NIL) prev_of[cur] = 13'(rq.node);
            if (prv < NIL) next_of[prv] = 13'(rq.node);
            else head[b] = 13'(rq.node);
            busy[rq.node] = 1'b1;
            linked++;
            r.status = ST_DONE;
        end else if (rq.cmd == CMD_REMOVE && busy[rq.node]) begin
            nx = next_of[rq.node];
            pv = prev_of[rq.node];
            if (nx < NIL) prev_of[nx] = pv;
            if (pv < NIL) next_of[pv] = nx;
            else head[bucket_for(key_lo_of[rq.node], key_hi_of[rq.node])] = nx;
            busy[rq.node] = 1'b0;
            if (linked > 0) linked--;
            r.status = ST_DONE;
        end else if (rq.cmd == CMD_FIND) begin
            cur = head[bucket_for(rq.key_lo, rq.key_hi)];
            steps = 0;
            r.status = ST_NOTFOUND;
            while (cur < NIL && steps < NODES) begin
                if (key_lo_of[cur] == rq.key_lo && key_hi_of[cur] == rq.key_hi) begin
                    r.status = ST_DONE;
                    r.found = cur[11:0];
                    break;
                end
                cur = next_of[cur];
                steps++;
            end
        end
        r.count = linked;
        return r;
    endfunction

    function automatic int phase_now();
        return (in_accepted * 4) / (total_words + 1);
    endfunction

    // Driver: a word is held until the monitor has counted its acceptance.
    always @(negedge aclk) begin
        request_t rq;
        int ph;
        ph = phase_now();
        if (aresetn) begin
            m_tready <= !((ph == 2 && $urandom_range(99) < 84) ||
                          (ph == 3 && $urandom_range(99) < 37));
            if (!(s_tvalid && in_accepted != drv_issued)) begin
                if (pending_words.size() != 0 &&
                    !((ph == 1 && $urandom_range(99) < 84) ||
                      (ph == 3 && $urandom_range(99) < 37))) begin
                    rq = pending_words.pop_front();
                    s_tdata <= {4'b0, rq.key_hi, rq.key_lo, rq.node};
                    s_tuser <= rq.cmd;
                    s_tvalid <= 1'b1;
                    drv_issued++;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: predicts on each accepted request and checks each reply word.
    always @(posedge aclk) begin
        request_t rq;
        reply_t want, got;
        if (aresetn) begin
            quiet_cycles++;
            if (s_tvalid && s_tready) begin
                rq.cmd = s_tuser;
                rq.node = s_tdata[11:0];
                rq.key_lo = s_tdata[75:12];
                rq.key_hi = s_tdata[107:76];
                awaited_replies.push_back(apply_command(rq));
                in_accepted++;
                quiet_cycles = 0;
            end
            if (m_tvalid && m_tready) begin
                quiet_cycles = 0;
                got = '{status: m_tdata[1:0], found: m_tdata[13:2], count: m_tdata[26:14]};
                if (awaited_replies.size() == 0) begin
                    $display("%0t: unexpected reply, expected none, actual %h", $time, got);
                    failures++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        failures++;
                    end
                    if (got.found !== want.found) begin
                        $display("%0t: found_node expected %0d actual %0d",
                                 $time, want.found, got.found);
                        failures++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.count, got.count);
                        failures++;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic queue_word(logic [1:0] c, logic [11:0] n, logic [95:0] k);
        pending_words.push_back('{cmd: c, node: n, key_lo: k[63:0], key_hi: k[95:64]});
    endtask

    initial begin
        logic [95:0] base_key, trial, k;
        int unsigned base_bucket;
        int r;
        logic [11:0] n;
        logic [1:0] c;
        for (int i = 0; i < BUCKETS; i++) head[i] = NIL;
        for (int i = 0; i < NODES; i++) busy[i] = 1'b0;
        linked = '0;

        // Gather a few keys that share one bucket so that chains form.
        base_key = {$urandom, $urandom, $urandom};
        base_bucket = bucket_for(base_key[63:0], base_key[95:64]);
        key_pool.push_back(base_key);
        for (int t = 0; t < 600000 && key_pool.size() < 5; t++) begin
            trial = {$urandom, $urandom, $urandom};
            if (bucket_for(trial[63:0], trial[95:64]) == base_bucket)
                key_pool.push_back(trial);
        end
        while (key_pool.size() < 5) key_pool.push_back({$urandom, $urandom, $urandom});
        key_pool.push_back('0);
        key_pool.push_back('1);
        for (int i = 0; i < 7; i++) key_pool.push_back({$urandom, $urandom, $urandom});

        // Directed opening.
        queue_word(CMD_INSERT, 12'd0, '0);
        queue_word(CMD_INSERT, 12'd4095, '1);
        queue_word(CMD_INSERT, 12'd0, '1);
        queue_word(CMD_FIND, 12'd4095, '1);
        queue_word(CMD_FIND, 12'd0, key_pool[7]);
        queue_word(CMD_INSERT, 12'd1, '1);
        queue_word(CMD_FIND, 12'd0, '1);
        queue_word(CMD_REMOVE, 12'd5, '0);
        queue_word(CMD_REMOVE, 12'd1, '0);
        queue_word(CMD_FIND, 12'd0, '1);
        queue_word(CMD_INSERT, 12'd2, key_pool[0]);
        queue_word(CMD_INSERT, 12'd3, key_pool[1]);
        queue_word(CMD_INSERT, 12'd4, key_pool[2]);
        queue_word(CMD_FIND, 12'd0, key_pool[2]);
        queue_word(CMD_REMOVE, 12'd3, '0);
        queue_word(CMD_FIND, 12'd0, key_pool[1]);
        queue_word(CMD_FIND, 12'd0, key_pool[2]);
        queue_word(CMD_SPARE, 12'd6, key_pool[3]);
        queue_word(CMD_REMOVE, 12'd2, '0);
        queue_word(CMD_FIND, 12'd0, key_pool[2]);
        queue_word(CMD_REMOVE, 12'd0, '1);
        queue_word(CMD_REMOVE, 12'd4095, '1);
        queue_word(CMD_REMOVE, 12'd4, '0);

        // Random part: a small node range keeps both busy and free nodes in play.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            r = $urandom_range(99);
            c = (r < 40) ? CMD_INSERT : (r < 70) ? CMD_REMOVE : (r < 95) ? CMD_FIND : CMD_SPARE;
            n = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(31));
            k = ($urandom_range(9) < 7) ? key_pool[$urandom_range(key_pool.size() - 1)]
                                        : {$urandom, $urandom, $urandom};
            queue_word(c, n, k);
        end
        total_words = pending_words.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        forever begin
            @(posedge aclk);
            if (pending_words.size() == 0 && in_accepted == drv_issued &&
                awaited_replies.size() == 0)
                break;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0 && awaited_replies.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/sfht_pkg.sv
sv/sfht_hash.sv
sv/session_flow_hash_table_core.sv
sv/sfht_checker.sv
verif/testbench.sv
